FILE: design/mciir_pkg.sv
// ----------------------------------------------------------------------------
// mciir_pkg
// Shared types and constants for the multichannel fourth-order IIR filter:
// history row layout, memory port requests, register indexes and reset values.
// ----------------------------------------------------------------------------
package mciir_pkg;

  // Channel count and history memory geometry
  localparam int CHANNELS = 8;
  localparam int ROW_W    = 3;
  localparam int CHAN_W   = 3;
  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 40;
  localparam int ACC_W    = 64;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_B_OUTER  = 3'd0,
    REG_B_INNER  = 3'd1,
    REG_B_MIDDLE = 3'd2,
    REG_A_ONE    = 3'd3,
    REG_A_TWO    = 3'd4,
    REG_A_THREE  = 3'd5,
    REG_A_FOUR   = 3'd6
  } reg_index_t;

  // Coefficient reset values, Q3.36
  localparam logic signed [COEF_W-1:0] B_OUTER_RST  = 40'sd1033971;
  localparam logic signed [COEF_W-1:0] B_INNER_RST  = 40'sd4135884;
  localparam logic signed [COEF_W-1:0] B_MIDDLE_RST = 40'sd6203825;
  localparam logic signed [COEF_W-1:0] A_ONE_RST    = -40'sd256006507840;
  localparam logic signed [COEF_W-1:0] A_TWO_RST    = 40'sd359128260300;
  localparam logic signed [COEF_W-1:0] A_THREE_RST  = -40'sd224774673895;
  localparam logic signed [COEF_W-1:0] A_FOUR_RST   = 40'sd52949999222;

  typedef logic [ROW_W-1:0] row_addr_t;

  // One channel's history: four past inputs and four past outputs (Q23.16)
  typedef struct packed {
    logic signed [COEF_W-1:0]   y4;
    logic signed [COEF_W-1:0]   y3;
    logic signed [COEF_W-1:0]   y2;
    logic signed [COEF_W-1:0]   y1;
    logic signed [SAMPLE_W-1:0] x4;
    logic signed [SAMPLE_W-1:0] x3;
    logic signed [SAMPLE_W-1:0] x2;
    logic signed [SAMPLE_W-1:0] x1;
  } hist_row_t;

  typedef struct packed {
    logic      en;
    row_addr_t addr;
  } mem_rd_req_t;

  typedef struct packed {
    logic      en;
    row_addr_t addr;
    hist_row_t row;
  } mem_wr_req_t;

endpackage

FILE: design/mciir_hist_mem.sv
// ----------------------------------------------------------------------------
// mciir_hist_mem
// History memory, one row per channel. Registered read with write-first
// forwarding; a per-row valid bit makes unwritten rows read as zero.
// ----------------------------------------------------------------------------
module mciir_hist_mem
  import mciir_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  mem_rd_req_t rd_req,
  input  mem_wr_req_t wr_req,
  output hist_row_t   rd_row
);

  hist_row_t             mem [CHANNELS];
  hist_row_t             rd_data;
  logic                  rd_valid;
  logic [CHANNELS-1:0]   row_valid;
  logic                  fwd_hit;

  assign fwd_hit = wr_req.en && (wr_req.addr == rd_req.addr);

  // Row storage
  always_ff @(posedge clk) begin
    if (wr_req.en) begin
      mem[wr_req.addr] <= wr_req.row;
    end
  end

  // Registered read, new data wins on a same-row write
  always_ff @(posedge clk) begin
    if (rd_req.en) begin
      if (fwd_hit) begin
        rd_data <= wr_req.row;
      end else begin
        rd_data <= mem[rd_req.addr];
      end
    end
  end

  // Row valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (wr_req.en) begin
        row_valid[wr_req.addr] <= 1'b1;
      end
      if (rd_req.en) begin
        rd_valid <= row_valid[rd_req.addr] || fwd_hit;
      end
    end
  end

  assign rd_row = rd_valid ? rd_data : '0;

endmodule

FILE: design/multichannel_iir_fourth_order.sv
// ----------------------------------------------------------------------------
// multichannel_iir_fourth_order
// Fourth-order direct-form-I IIR low-pass shared by eight channels, with the
// per-channel histories held in one row-per-channel memory.
// ----------------------------------------------------------------------------
// Each request names a channel. A filter request (command 0) reads that
// channel's history row, forms the feedforward and split feedback products,
// sums them in two adder stages, rounds to Q23.16, writes the shifted history
// back and returns the output rounded to 16 bits with a saturation flag. A
// preset request (command 1) fills the channel's history with its level and
// echoes the level. The pipeline takes one request per cycle while the output
// is not stalled and no request ahead of write-back uses the same channel; a
// request for a channel still in flight waits until that channel's write-back,
// so it waits out the memory read, multiply, partial sums and accumulate steps
// of the request before it. History is zero after reset without a clearing
// pass. Coefficients are to be written by the user only while the block is
// idle; the block itself does not enforce this.
module multichannel_iir_fourth_order
  import mciir_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [2:0]                 cfg_index,
  input  logic [COEF_W-1:0]          cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       command,
  input  logic [CHAN_W-1:0]          channel,
  input  logic signed [SAMPLE_W-1:0] sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [CHAN_W-1:0]          out_channel,
  output logic signed [SAMPLE_W-1:0] filtered,
  output logic                       clipped
);

  typedef struct packed {
    logic                       cmd;
    logic [CHAN_W-1:0]          chan;
    logic                       ok;
    logic signed [SAMPLE_W-1:0] x;
  } item_t;

  localparam logic signed [ACC_W-1:0]  ACC_HALF = 64'sd32768;
  localparam logic signed [COEF_W-1:0] Y_MAX    = 40'sh7FFFFFFFFF;
  localparam logic signed [COEF_W-1:0] Y_MIN    = 40'sh8000000000;

  // Coefficient registers
  logic signed [COEF_W-1:0] coef_b_outer;
  logic signed [COEF_W-1:0] coef_b_inner;
  logic signed [COEF_W-1:0] coef_b_middle;
  logic signed [COEF_W-1:0] coef_a_one;
  logic signed [COEF_W-1:0] coef_a_two;
  logic signed [COEF_W-1:0] coef_a_three;
  logic signed [COEF_W-1:0] coef_a_four;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b_outer  <= B_OUTER_RST;
      coef_b_inner  <= B_INNER_RST;
      coef_b_middle <= B_MIDDLE_RST;
      coef_a_one    <= A_ONE_RST;
      coef_a_two    <= A_TWO_RST;
      coef_a_three  <= A_THREE_RST;
      coef_a_four   <= A_FOUR_RST;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_B_OUTER:  coef_b_outer  <= cfg_data;
        REG_B_INNER:  coef_b_inner  <= cfg_data;
        REG_B_MIDDLE: coef_b_middle <= cfg_data;
        REG_A_ONE:    coef_a_one    <= cfg_data;
        REG_A_TWO:    coef_a_two    <= cfg_data;
        REG_A_THREE:  coef_a_three  <= cfg_data;
        REG_A_FOUR:   coef_a_four   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline control
  logic      adv;
  logic      hazard;
  logic      accept;
  logic      s1_valid, s2_valid, s3_valid, s4_valid;
  item_t     s1_item, s2_item, s3_item, s4_item;
  hist_row_t s2_row, s3_row, s4_row;
  hist_row_t rd_row;
  mem_rd_req_t rd_req;
  mem_wr_req_t wr_req;

  assign adv    = !out_valid || out_ready;
  // the write-back stage forwards into the read, earlier stages must drain
  assign hazard = (s1_valid && s1_item.chan == channel) ||
                  (s2_valid && s2_item.chan == channel) ||
                  (s3_valid && s3_item.chan == channel);
  assign in_ready = adv && !hazard;
  assign accept   = in_valid && in_ready;

  assign rd_req.en   = accept;
  assign rd_req.addr = channel[ROW_W-1:0];

  mciir_hist_mem u_hist_mem (
    .clk    (clk),
    .rst    (rst),
    .rd_req (rd_req),
    .wr_req (wr_req),
    .rd_row (rd_row)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  // Stage 1: request capture, history arrives from memory
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item.cmd  <= command;
      s1_item.chan <= channel;
      s1_item.ok   <= (int'(channel) < CHANNELS);
      s1_item.x    <= sample;
    end
  end

  // Stage 1 datapath: pre-adds and products
  logic signed [SAMPLE_W:0]   pre_outer;
  logic signed [SAMPLE_W:0]   pre_inner;
  logic signed [COEF_W-1:0]   fb_coef [4];
  logic signed [COEF_W-1:0]   y_hist  [4];
  logic signed [19:0]         y_hi    [4];
  logic signed [20:0]         y_lo    [4];
  logic signed [56:0]         p_ff_next [3];
  logic signed [59:0]         p_hi_next [4];
  logic signed [60:0]         p_lo_next [4];
  logic signed [56:0]         p_ff [3];
  logic signed [59:0]         p_hi [4];
  logic signed [60:0]         p_lo [4];

  assign pre_outer = {s1_item.x[SAMPLE_W-1], s1_item.x} + {rd_row.x4[SAMPLE_W-1], rd_row.x4};
  assign pre_inner = {rd_row.x1[SAMPLE_W-1], rd_row.x1} + {rd_row.x3[SAMPLE_W-1], rd_row.x3};

  assign fb_coef[0] = coef_a_one;
  assign fb_coef[1] = coef_a_two;
  assign fb_coef[2] = coef_a_three;
  assign fb_coef[3] = coef_a_four;
  assign y_hist[0]  = rd_row.y1;
  assign y_hist[1]  = rd_row.y2;
  assign y_hist[2]  = rd_row.y3;
  assign y_hist[3]  = rd_row.y4;

  always_comb begin
    p_ff_next[0] = coef_b_outer * pre_outer;
    p_ff_next[1] = coef_b_inner * pre_inner;
    p_ff_next[2] = coef_b_middle * rd_row.x2;
    // feedback y split into signed high and unsigned low 20-bit halves
    for (int k = 0; k < 4; k++) begin
      y_hi[k]      = y_hist[k][39:20];
      y_lo[k]      = {1'b0, y_hist[k][19:0]};
      p_hi_next[k] = fb_coef[k] * y_hi[k];
      p_lo_next[k] = fb_coef[k] * y_lo[k];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_item <= s1_item;
      s2_row  <= rd_row;
      p_ff    <= p_ff_next;
      p_hi    <= p_hi_next;
      p_lo    <= p_lo_next;
    end
  end

  // Stage 2: partial sums in Q.32
  logic signed [ACC_W-1:0] sum_ff, sum_hi, sum_lo;
  logic signed [ACC_W-1:0] sum_ff_next, sum_hi_next, sum_lo_next;

  always_comb begin
    sum_ff_next = ACC_W'(p_ff[0] >>> 4) + ACC_W'(p_ff[1] >>> 4) + ACC_W'(p_ff[2] >>> 4);
    sum_hi_next = ACC_W'(p_hi[0]) + ACC_W'(p_hi[1]) + ACC_W'(p_hi[2]) + ACC_W'(p_hi[3]);
    sum_lo_next = ACC_W'(p_lo[0] >>> 20) + ACC_W'(p_lo[1] >>> 20) +
                  ACC_W'(p_lo[2] >>> 20) + ACC_W'(p_lo[3] >>> 20);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_item <= s2_item;
      s3_row  <= s2_row;
      sum_ff  <= sum_ff_next;
      sum_hi  <= sum_hi_next;
      sum_lo  <= sum_lo_next;
    end
  end

  // Stage 3: accumulate with rounding offset
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_next;

  assign acc_next = sum_ff - sum_hi - sum_lo + ACC_HALF;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_item <= s3_item;
      s4_row  <= s3_row;
      acc     <= acc_next;
    end
  end

  // Stage 4: round, saturate, write back, result
  logic signed [ACC_W-17:0]    y_wide;
  logic signed [COEF_W-1:0]    y_sat;
  logic signed [COEF_W:0]      y_rnd;
  logic signed [24:0]          f_wide;
  logic                        f_hi, f_lo;
  logic signed [SAMPLE_W-1:0]  f_sat;
  logic signed [COEF_W-1:0]    preset_y;
  hist_row_t                   new_row;
  logic signed [SAMPLE_W-1:0]  filtered_next;
  logic                        clipped_next;

  always_comb begin
    y_wide = acc[ACC_W-1:16];
    if (!y_wide[ACC_W-17] && (|y_wide[ACC_W-18:COEF_W-1])) begin
      y_sat = Y_MAX;
    end else if (y_wide[ACC_W-17] && !(&y_wide[ACC_W-18:COEF_W-1])) begin
      y_sat = Y_MIN;
    end else begin
      y_sat = y_wide[COEF_W-1:0];
    end

    y_rnd  = {y_sat[COEF_W-1], y_sat} + 41'sd32768;
    f_wide = y_rnd[COEF_W:16];
    f_hi   = !f_wide[24] && (|f_wide[23:15]);
    f_lo   = f_wide[24] && !(&f_wide[23:15]);
    if (f_hi) begin
      f_sat = 16'sh7FFF;
    end else if (f_lo) begin
      f_sat = 16'sh8000;
    end else begin
      f_sat = f_wide[15:0];
    end

    preset_y = {{8{s4_item.x[SAMPLE_W-1]}}, s4_item.x, 16'h0000};

    if (s4_item.cmd) begin
      new_row.x1 = s4_item.x;
      new_row.x2 = s4_item.x;
      new_row.x3 = s4_item.x;
      new_row.x4 = s4_item.x;
      new_row.y1 = preset_y;
      new_row.y2 = preset_y;
      new_row.y3 = preset_y;
      new_row.y4 = preset_y;
    end else begin
      new_row.x1 = s4_item.x;
      new_row.x2 = s4_row.x1;
      new_row.x3 = s4_row.x2;
      new_row.x4 = s4_row.x3;
      new_row.y1 = y_sat;
      new_row.y2 = s4_row.y1;
      new_row.y3 = s4_row.y2;
      new_row.y4 = s4_row.y3;
    end

    // out-of-range channel: zero result, history untouched
    if (!s4_item.ok) begin
      filtered_next = '0;
      clipped_next  = 1'b0;
    end else if (s4_item.cmd) begin
      filtered_next = s4_item.x;
      clipped_next  = 1'b0;
    end else begin
      filtered_next = f_sat;
      clipped_next  = f_hi || f_lo;
    end
  end

  assign wr_req.en   = adv && s4_valid && s4_item.ok;
  assign wr_req.addr = s4_item.chan[ROW_W-1:0];
  assign wr_req.row  = new_row;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s4_valid) begin
      out_channel <= s4_item.chan;
      filtered    <= filtered_next;
      clipped     <= clipped_next;
    end
  end

endmodule

FILE: design/mciir_checker.sv
// ----------------------------------------------------------------------------
// mciir_checker
// Port-level checks for the multichannel IIR filter, bound to the top level.
// ----------------------------------------------------------------------------
module mciir_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [2:0]        out_channel,
  input logic signed [15:0] filtered,
  input logic              clipped
);

  // A waiting result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_channel) &&
      $stable(filtered) && $stable(clipped))
    else $error("result changed while stalled");

  // Reset empties the output stage
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

  // A clipped result sits on a rail
  a_clip_rail: assert property (@(posedge clk) disable iff (rst)
    out_valid && clipped |-> filtered == 16'sh7FFF || filtered == 16'sh8000)
    else $error("clipped result not at a rail");

  // A stalled output blocks new requests
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("request accepted while output stalled");

endmodule

bind multichannel_iir_fourth_order mciir_checker u_mciir_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_channel (out_channel),
  .filtered    (filtered),
  .clipped     (clipped)
);
